[hw/rtl/ffa_pkg.sv]
package ffa_pkg;

    // default heap depth in 8-byte units
    localparam int unsigned HEAP_UNITS_DEF = 4096;

    // header layout: payload size in the low bits, used flag on top
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned HDR_W  = SIZE_W + 1;

    // rounded request in units, can reach 8192
    localparam int unsigned NEED_W = 14;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_ZERO     = 2'd1;
    localparam logic [1:0] RC_NO_SPACE = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic [11:0] block_addr;
    } req_beat_t;

    typedef struct packed {
        logic [11:0] payload_addr;
        logic [1:0]  result_code;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_WALK,
        ST_A_SPLIT,
        ST_APPEND,
        ST_F_HEAD,
        ST_F_WALK,
        ST_RESP
    } state_t;

endpackage

[hw/rtl/ffa_ram.sv]
module ffa_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/first_fit_block_allocator.sv]
// allocate: walk headers from unit 0, append at the heap top when none fits, and split
// a fit with room left over; a zero-size request goes straight to the result
// free: an invalid address goes straight to the result, else the freed block merges with
// each free block behind it; one walk step per cycle, set by the single read port of the
// header ram; req_stall drops as the result registers, even one that is then stalled
// reset clears control state, empties the heap and sets the limit to 4096 units
module first_fit_block_allocator
    import ffa_pkg::*;
#(
    parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_beat_t         req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_beat_t         rsp
);

    // header ram index width and pointer width; pointers carry headroom for
    // a walk step that runs past the heap top
    localparam int unsigned AW = $clog2(HEAP_UNITS);
    localparam int unsigned PW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;

    state_t state_reg, state_next;

    logic [PW-1:0]     cur_reg, cur_next;        // header being looked at
    logic [PW-1:0]     hdr_reg, hdr_next;        // header being freed
    logic [NEED_W-1:0] need_reg, need_next;      // request in units
    logic [SIZE_W-1:0] acc_reg, acc_next;        // merged size or split size
    logic [PW-1:0]     heap_top_reg, heap_top_next;
    logic [SIZE_W-1:0] limit_reg;
    logic [11:0]       res_addr_reg, res_addr_next;
    logic [1:0]        res_code_reg, res_code_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_beat_t         rsp_reg, rsp_next;

    // header ram ports
    logic              ram_we, ram_re;
    logic [PW-1:0]     ram_wptr, ram_rptr;
    logic [HDR_W-1:0]  ram_wdata, ram_rdata;

    // header read back, valid in the walk states
    logic [SIZE_W-1:0] rd_size;
    logic              rd_used;

    // the shared adder: base + operand + 1
    logic [PW-1:0]     add_base;
    logic [NEED_W-1:0] add_opnd;
    logic [PW-1:0]     add_sum;
    logic              sum_in_heap;

    logic              accept;
    logic [16:0]       bytes_round;
    logic [NEED_W-1:0] need_c;
    logic [11:0]       free_hdr;
    logic              free_ok;
    logic              fits;
    logic [SIZE_W-1:0] rem;
    logic [PW-1:0]     limit_eff;
    logic              no_space;
    logic              rsp_free;

    ffa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wptr[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_rptr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // shared decode
    // ---------------------------------------------------------------
    assign accept  = req_valid && !req_stall;
    assign rd_size = ram_rdata[SIZE_W-1:0];
    assign rd_used = ram_rdata[SIZE_W];

    // bytes rounded up to whole 8-byte units
    assign bytes_round = {1'b0, req.request_bytes} + 17'd7;
    assign need_c      = bytes_round[16:3];

    assign free_hdr = req.block_addr - 12'd1;
    assign free_ok  = (req.block_addr != 12'd0) && (PW'(free_hdr) < heap_top_reg);

    // append grows from the heap top, a split lands past the new block,
    // a walk step skips over the header just read
    assign add_base = (state_reg == ST_APPEND) ? heap_top_reg : cur_reg;
    assign add_opnd = (state_reg inside {ST_APPEND, ST_A_SPLIT}) ? need_reg
                                                                 : {1'b0, rd_size};
    assign add_sum     = add_base + PW'(add_opnd) + PW'(1);
    assign sum_in_heap = add_sum < heap_top_reg;

    // exact fit, or enough left over for a header and one payload unit
    assign fits = !rd_used
               && (({1'b0, rd_size} == need_reg)
                   || ({2'b00, rd_size} >= ({1'b0, need_reg} + 15'd2)));
    assign rem  = rd_size - need_reg[SIZE_W-1:0];

    assign limit_eff = (PW'(limit_reg) < PW'(HEAP_UNITS)) ? PW'(limit_reg)
                                                          : PW'(HEAP_UNITS);
    assign no_space  = add_sum > limit_eff;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_FREE)
                    begin
                        state_next = free_ok ? ST_F_HEAD : ST_RESP;
                    end
                    else if (req.request_bytes == 16'd0)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (heap_top_reg == '0)
                    begin
                        state_next = ST_APPEND;
                    end
                    else
                    begin
                        state_next = ST_A_WALK;
                    end
                end
            end
            ST_A_WALK:
            begin
                if (fits)
                begin
                    state_next = (rem != '0) ? ST_A_SPLIT : ST_RESP;
                end
                else if (!sum_in_heap)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_A_SPLIT: state_next = ST_RESP;
            ST_APPEND:  state_next = ST_RESP;
            ST_F_HEAD:
            begin
                state_next = sum_in_heap ? ST_F_WALK : ST_RESP;
            end
            ST_F_WALK:
            begin
                if (rd_used || !sum_in_heap)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath and ram control
    // ---------------------------------------------------------------
    always_comb
    begin
        cur_next       = cur_reg;
        hdr_next       = hdr_reg;
        need_next      = need_reg;
        acc_next       = acc_reg;
        heap_top_next  = heap_top_reg;
        res_addr_next  = res_addr_reg;
        res_code_next  = res_code_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_wptr       = cur_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_rptr       = add_sum;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next = 12'd0;
                    res_code_next = RC_OK;
                    need_next     = need_c;
                    if (req.cmd == CMD_FREE)
                    begin
                        cur_next = PW'(free_hdr);
                        hdr_next = PW'(free_hdr);
                        ram_re   = free_ok;
                        ram_rptr = PW'(free_hdr);
                    end
                    else if (req.request_bytes == 16'd0)
                    begin
                        res_code_next = RC_ZERO;
                    end
                    else
                    begin
                        // first fit walk starts at unit 0
                        cur_next = '0;
                        ram_re   = (heap_top_reg != '0);
                        ram_rptr = '0;
                    end
                end
            end
            ST_A_WALK:
            begin
                if (fits)
                begin
                    ram_we        = 1'b1;
                    ram_wptr      = cur_reg;
                    ram_wdata     = {1'b1, need_reg[SIZE_W-1:0]};
                    acc_next      = rem - SIZE_W'(1);
                    res_addr_next = 12'(cur_reg + PW'(1));
                end
                else
                begin
                    cur_next = add_sum;
                    ram_re   = sum_in_heap;
                end
            end
            ST_A_SPLIT:
            begin
                // remainder becomes a free block right after the new one
                ram_we    = add_sum < PW'(HEAP_UNITS);
                ram_wptr  = add_sum;
                ram_wdata = {1'b0, acc_reg};
            end
            ST_APPEND:
            begin
                if (no_space)
                begin
                    res_code_next = RC_NO_SPACE;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_wptr      = heap_top_reg;
                    ram_wdata     = {1'b1, need_reg[SIZE_W-1:0]};
                    heap_top_next = add_sum;
                    res_addr_next = 12'(heap_top_reg + PW'(1));
                end
            end
            ST_F_HEAD:
            begin
                acc_next = rd_size;
                cur_next = add_sum;
                if (sum_in_heap)
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wptr  = hdr_reg;
                    ram_wdata = {1'b0, rd_size};
                end
            end
            ST_F_WALK:
            begin
                if (rd_used)
                begin
                    ram_we    = 1'b1;
                    ram_wptr  = hdr_reg;
                    ram_wdata = {1'b0, acc_reg};
                end
                else
                begin
                    // absorb this free block and its header, sizes wrap
                    acc_next = acc_reg + rd_size + SIZE_W'(1);
                    cur_next = add_sum;
                    if (sum_in_heap)
                    begin
                        ram_re = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wptr  = hdr_reg;
                        ram_wdata = {1'b0, acc_next};
                    end
                end
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.payload_addr = res_addr_reg;
                    rsp_next.result_code  = res_code_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heap_top_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_top_reg  <= heap_top_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        hdr_reg      <= hdr_next;
        need_reg     <= need_next;
        acc_reg      <= acc_next;
        res_addr_reg <= res_addr_next;
        res_code_reg <= res_code_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        heap_top_reg <= PW'(HEAP_UNITS))
        else $error("heap top past the end of the store");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_wptr < PW'(HEAP_UNITS)))
        else $error("header write outside the store");

    a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("header read and write in the same cycle");

    a_top_moves_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heap_top_reg) |-> $past(state_reg == ST_APPEND))
        else $error("heap top moved outside an append");

    a_fail_has_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.result_code != RC_OK)) |-> (rsp.payload_addr == 12'd0))
        else $error("failed allocate returned an address");

endmodule
